// ----- rtl/glt_pkg.sv -----
// ----------------------------------------------------------------------------
// glt_pkg
// Types, codes and keyword tables shared by the gate library tokenizer.
// ----------------------------------------------------------------------------
package glt_pkg;

    localparam int KIND_W  = 5;
    localparam int CHAR_W  = 8;
    localparam int STATE_W = 4;
    localparam int KW_N    = 7;
    localparam int LEN_W   = 3;

    // token kinds
    localparam logic [KIND_W-1:0] K_CHAR  = 5'd0;
    localparam logic [KIND_W-1:0] K_STR   = 5'd1;
    localparam logic [KIND_W-1:0] K_NUM   = 5'd2;
    localparam logic [KIND_W-1:0] K_KW0   = 5'd3;
    localparam logic [KIND_W-1:0] K_SEMI  = 5'd10;
    localparam logic [KIND_W-1:0] K_EQ    = 5'd11;
    localparam logic [KIND_W-1:0] K_LP    = 5'd12;
    localparam logic [KIND_W-1:0] K_RP    = 5'd13;
    localparam logic [KIND_W-1:0] K_NOT   = 5'd14;
    localparam logic [KIND_W-1:0] K_STAR  = 5'd15;
    localparam logic [KIND_W-1:0] K_PLUS  = 5'd16;
    localparam logic [KIND_W-1:0] K_HAT   = 5'd17;
    localparam logic [KIND_W-1:0] K_ERROR = 5'd18;
    localparam logic [KIND_W-1:0] K_EOF   = 5'd19;

    // lexer states
    localparam logic [STATE_W-1:0] S_START = 4'd0;
    localparam logic [STATE_W-1:0] S_IDENT = 4'd1;
    localparam logic [STATE_W-1:0] S_INT   = 4'd2;
    localparam logic [STATE_W-1:0] S_DOT   = 4'd3;
    localparam logic [STATE_W-1:0] S_FRAC  = 4'd4;
    localparam logic [STATE_W-1:0] S_EXP   = 4'd5;
    localparam logic [STATE_W-1:0] S_EXPD  = 4'd6;
    localparam logic [STATE_W-1:0] S_CMT   = 4'd7;
    localparam logic [STATE_W-1:0] S_QSTR  = 4'd8;

    localparam logic [CHAR_W-1:0] KW_TEXT [KW_N][8] = '{
        '{"G", "A", "T", "E", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "I", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"N", "O", "N", "I", "N", "V", 8'h00, 8'h00},
        '{"I", "N", "V", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"U", "N", "K", "N", "O", "W", "N", 8'h00},
        '{"C", "O", "N", "S", "T", "0", 8'h00, 8'h00},
        '{"C", "O", "N", "S", "T", "1", 8'h00, 8'h00}
    };

    localparam logic [LEN_W-1:0] KW_LEN [KW_N] = '{
        3'd4, 3'd3, 3'd6, 3'd3, 3'd7, 3'd6, 3'd6
    };

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] chr;
        logic              last;
    } tok_t;

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

endpackage

// ----- rtl/glt_step.sv -----
// ----------------------------------------------------------------------------
// glt_step
// Next-state and result logic of the lexer for one input word; a word that
// ends an identifier or a number also restarts from the start state, giving up to two results.
// ----------------------------------------------------------------------------
module glt_step #(
    parameter int COLUMN_BITS = 16
) (
    input  logic [glt_pkg::STATE_W-1:0] state,
    input  logic [glt_pkg::KW_N-1:0]    alive,
    input  logic [glt_pkg::LEN_W-1:0]   len,
    input  logic [COLUMN_BITS-1:0]      start_col,
    input  logic [COLUMN_BITS-1:0]      end_col,
    input  logic [glt_pkg::CHAR_W-1:0]  ch,
    input  logic [COLUMN_BITS-1:0]      column,
    input  logic                        end_of_input,
    output logic [glt_pkg::STATE_W-1:0] nxt_state,
    output logic [glt_pkg::KW_N-1:0]    nxt_alive,
    output logic [glt_pkg::LEN_W-1:0]   nxt_len,
    output logic [COLUMN_BITS-1:0]      nxt_start,
    output logic [COLUMN_BITS-1:0]      nxt_end,
    output glt_pkg::tok_t               r0,
    output logic [COLUMN_BITS-1:0]      r0_first,
    output logic [COLUMN_BITS-1:0]      r0_last,
    output glt_pkg::tok_t               r1,
    output logic [COLUMN_BITS-1:0]      r1_first,
    output logic [COLUMN_BITS-1:0]      r1_last
);
    import glt_pkg::*;

    logic                dig;
    logic                alpha;
    logic                is_e;
    logic [STATE_W-1:0]  st_state;
    tok_t                st_tok;
    logic                st_ident;
    logic [KW_N-1:0]     st_alive;
    logic [KW_N-1:0]     upd_alive;
    logic [KIND_W-1:0]   id_kind;
    logic                again;
    logic                use_start;
    tok_t                chr_tok;
    tok_t                r0_raw;
    tok_t                r1_raw;

    assign dig     = !end_of_input && is_digit(ch);
    assign alpha   = !end_of_input && (is_alpha(ch) || ch == "_");
    assign is_e    = !end_of_input && (ch == "E" || ch == "e");
    assign chr_tok = '{1'b1, K_CHAR, ch, 1'b0};

    always_comb
    begin
        for (int k = 0; k < KW_N; k++)
        begin
            st_alive[k]  = (KW_TEXT[k][0] == ch);
            upd_alive[k] = alive[k] && (len < KW_LEN[k]) && (KW_TEXT[k][len] == ch);
        end
        id_kind = K_STR;
        for (int k = KW_N - 1; k >= 0; k--)
        begin
            if (alive[k] && KW_LEN[k] == len)
                id_kind = KIND_W'(int'(K_KW0) + k);
        end
    end

    // start-state handling of the current character
    always_comb
    begin
        st_state = S_START;
        st_tok   = '0;
        st_ident = 1'b0;
        if (end_of_input)
            st_tok = '{1'b1, K_EOF, 8'h00, 1'b0};
        else if (alpha)
        begin
            st_state = S_IDENT;
            st_ident = 1'b1;
            st_tok   = chr_tok;
        end
        else if (is_digit(ch) || ch == "-")
        begin
            st_state = S_INT;
            st_tok   = chr_tok;
        end
        else
        begin
            case (ch)
                " ", "\t", "\n": ;
                ".":
                begin
                    st_state = S_DOT;
                    st_tok   = chr_tok;
                end
                ";":      st_tok = '{1'b1, K_SEMI, 8'h00, 1'b0};
                "=":      st_tok = '{1'b1, K_EQ, 8'h00, 1'b0};
                "(":      st_tok = '{1'b1, K_LP, 8'h00, 1'b0};
                ")":      st_tok = '{1'b1, K_RP, 8'h00, 1'b0};
                "!":      st_tok = '{1'b1, K_NOT, 8'h00, 1'b0};
                "*", "&": st_tok = '{1'b1, K_STAR, 8'h00, 1'b0};
                "+", "|": st_tok = '{1'b1, K_PLUS, 8'h00, 1'b0};
                "^":      st_tok = '{1'b1, K_HAT, 8'h00, 1'b0};
                "#":      st_state = S_CMT;
                "\"":     st_state = S_QSTR;
                default:  st_tok = '{1'b1, K_ERROR, 8'h00, 1'b0};
            endcase
        end
    end

    always_comb
    begin
        nxt_state = state;
        nxt_alive = alive;
        nxt_len   = len;
        nxt_start = start_col;
        nxt_end   = end_col;
        r0_raw    = '0;
        r0_first  = start_col;
        r0_last   = end_col;
        r1_raw    = '0;
        r1_first  = column;
        r1_last   = column;
        again     = 1'b0;
        use_start = 1'b0;

        unique case (state)
            S_START: use_start = 1'b1;
            S_IDENT:
            begin
                if (alpha || dig)
                begin
                    r0_raw    = chr_tok;
                    r0_last   = column;
                    nxt_end   = column;
                    nxt_alive = upd_alive;
                    nxt_len   = (len == {LEN_W{1'b1}}) ? len : len + 1'b1;
                end
                else
                begin
                    r0_raw = '{1'b1, id_kind, 8'h00, 1'b0};
                    again  = 1'b1;
                end
            end
            S_INT, S_FRAC:
            begin
                if (dig || is_e || (state == S_INT && !end_of_input && ch == "."))
                begin
                    r0_raw  = chr_tok;
                    r0_last = column;
                    nxt_end = column;
                    if (is_e)
                        nxt_state = S_EXP;
                    else if (!dig)
                        nxt_state = S_FRAC;
                end
                else
                begin
                    r0_raw = '{1'b1, K_NUM, 8'h00, 1'b0};
                    again  = 1'b1;
                end
            end
            S_DOT:
            begin
                if (dig)
                begin
                    r0_raw    = chr_tok;
                    r0_last   = column;
                    nxt_end   = column;
                    nxt_state = S_FRAC;
                end
                else
                begin
                    r0_raw    = '{1'b1, K_ERROR, 8'h00, 1'b0};
                    nxt_state = S_START;
                end
            end
            S_EXP, S_EXPD:
            begin
                if (dig || (state == S_EXP && !end_of_input && ch == "-"))
                begin
                    r0_raw    = chr_tok;
                    r0_last   = column;
                    nxt_end   = column;
                    nxt_state = S_EXPD;
                end
                else
                begin
                    r0_raw = '{1'b1, K_NUM, 8'h00, 1'b0};
                    again  = 1'b1;
                end
            end
            S_CMT, S_QSTR:
            begin
                if (end_of_input)
                begin
                    r0_raw    = '{1'b1, K_EOF, 8'h00, 1'b0};
                    r0_first  = column;
                    r0_last   = column;
                    nxt_start = column;
                    nxt_end   = column;
                    nxt_state = S_START;
                end
                else if (state == S_CMT)
                begin
                    if (ch == "\n")
                        nxt_state = S_START;
                end
                else if (ch == "\"")
                begin
                    r0_raw    = '{1'b1, K_STR, 8'h00, 1'b0};
                    nxt_state = S_START;
                end
                else
                begin
                    r0_raw  = chr_tok;
                    r0_last = column;
                    nxt_end = column;
                end
            end
            default: use_start = 1'b1;
        endcase

        if (use_start || again)
        begin
            nxt_state = st_state;
            nxt_start = column;
            nxt_end   = column;
            if (st_ident)
            begin
                nxt_alive = st_alive;
                nxt_len   = LEN_W'(1);
            end
            if (again)
                r1_raw = st_tok;
            else
            begin
                r0_raw   = st_tok;
                r0_first = column;
                r0_last  = column;
            end
        end
    end

    always_comb
    begin
        r0      = r0_raw;
        r1      = r1_raw;
        r1.last = r1_raw.valid;
        r0.last = r0_raw.valid && !r1_raw.valid;
    end

endmodule

// ----- rtl/gate_library_tokenizer.sv -----
// ----------------------------------------------------------------------------
// gate_library_tokenizer
// Character-serial lexer for a gate cell library text format.
// ----------------------------------------------------------------------------
// A word's results are written into a 4-entry queue and offered from there.
// One word is taken per cycle unless the input stalls; a word with two
// results passes them one at a time to the single-result output port.
// Input stalls while the queue holds more than two results.
// Reset puts the lexer in its start state and empties the queue.
module gate_library_tokenizer #(
    parameter int COLUMN_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [glt_pkg::CHAR_W-1:0] ch,
    input  logic [COLUMN_BITS-1:0]     column,
    input  logic                       end_of_input,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [glt_pkg::KIND_W-1:0] kind,
    output logic [glt_pkg::CHAR_W-1:0] lexeme_char,
    output logic [COLUMN_BITS-1:0]     first_col,
    output logic [COLUMN_BITS-1:0]     last_col,
    output logic                       last
);
    import glt_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [STATE_W-1:0]     state_reg;
    logic [KW_N-1:0]        alive_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [COLUMN_BITS-1:0] start_col_reg;
    logic [COLUMN_BITS-1:0] end_col_reg;

    logic [STATE_W-1:0]     state_next;
    logic [KW_N-1:0]        alive_next;
    logic [LEN_W-1:0]       len_next;
    logic [COLUMN_BITS-1:0] start_col_next;
    logic [COLUMN_BITS-1:0] end_col_next;

    tok_t                   r0;
    tok_t                   r1;
    logic [COLUMN_BITS-1:0] r0_first;
    logic [COLUMN_BITS-1:0] r0_last;
    logic [COLUMN_BITS-1:0] r1_first;
    logic [COLUMN_BITS-1:0] r1_last;

    tok_t                   tok_reg   [DEPTH];
    logic [COLUMN_BITS-1:0] first_reg [DEPTH];
    logic [COLUMN_BITS-1:0] lastc_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic                   accept;
    logic                   pop;
    logic [CNT_W-1:0]       push_n;
    logic [PTR_W-1:0]       wr_ptr_1;

    glt_step #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_step (
        .state        (state_reg),
        .alive        (alive_reg),
        .len          (len_reg),
        .start_col    (start_col_reg),
        .end_col      (end_col_reg),
        .ch           (ch),
        .column       (column),
        .end_of_input (end_of_input),
        .nxt_state    (state_next),
        .nxt_alive    (alive_next),
        .nxt_len      (len_next),
        .nxt_start    (start_col_next),
        .nxt_end      (end_col_next),
        .r0           (r0),
        .r0_first     (r0_first),
        .r0_last      (r0_last),
        .r1           (r1),
        .r1_first     (r1_first),
        .r1_last      (r1_last)
    );

    assign in_stall = count_reg > CNT_W'(DEPTH - 2);
    assign accept   = in_valid && !in_stall;
    assign out_valid = count_reg != '0;
    assign pop      = out_valid && !out_stall;
    assign push_n   = accept ? (CNT_W'(r0.valid) + CNT_W'(r1.valid)) : '0;
    assign wr_ptr_1 = wr_ptr_reg + 1'b1;
    assign count_next = count_reg + push_n - CNT_W'(pop);

    assign kind        = tok_reg[rd_ptr_reg].kind;
    assign lexeme_char = tok_reg[rd_ptr_reg].chr;
    assign last        = tok_reg[rd_ptr_reg].last;
    assign first_col   = first_reg[rd_ptr_reg];
    assign last_col    = lastc_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_START;
            alive_reg     <= '1;
            len_reg       <= '0;
            start_col_reg <= '0;
            end_col_reg   <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                alive_reg     <= alive_next;
                len_reg       <= len_next;
                start_col_reg <= start_col_next;
                end_col_reg   <= end_col_next;
                wr_ptr_reg    <= wr_ptr_reg + PTR_W'(push_n);
            end
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && r0.valid)
        begin
            tok_reg[wr_ptr_reg]   <= r0;
            first_reg[wr_ptr_reg] <= r0_first;
            lastc_reg[wr_ptr_reg] <= r0_last;
        end
        if (accept && r1.valid)
        begin
            tok_reg[wr_ptr_1]   <= r1;
            first_reg[wr_ptr_1] <= r1_first;
            lastc_reg[wr_ptr_1] <= r1_last;
        end
    end

endmodule
